>>> sv/dbn_pkg.sv
// ----------------------------------------------------------------------------
// dbn_pkg
// shared types and constants of the diagnostic event debounce block
// ----------------------------------------------------------------------------
package dbn_pkg;

  // default counter width, legal range 8 to 32
  localparam int unsigned COUNT_W_DEF = 16;

  localparam int unsigned THR_W    = 16;  // threshold registers, signed
  localparam int unsigned STEP_W   = 15;  // step registers, unsigned
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // event status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PASSED    = 3'd0,
    ST_FAILED    = 3'd1,
    ST_PREPASSED = 3'd2,
    ST_PREFAILED = 3'd3,
    ST_INIT      = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAULT_THR = 3'd0,
    CFG_PASS_THR  = 3'd1,
    CFG_UP_STEP   = 3'd2,
    CFG_DOWN_STEP = 3'd3,
    CFG_HEAL_EN   = 3'd4
  } cfg_idx_t;

  // configuration reset values
  localparam logic signed [THR_W-1:0] FAULT_THR_RST = 16'sd10;
  localparam logic signed [THR_W-1:0] PASS_THR_RST  = -16'sd10;
  localparam logic [STEP_W-1:0]       UP_STEP_RST   = 15'd1;
  localparam logic [STEP_W-1:0]       DOWN_STEP_RST = 15'd1;
  localparam logic                    HEAL_EN_RST   = 1'b1;

  // one input sample
  typedef struct packed {
    logic fault_active;
    logic startup_complete;
    logic diag_reset;
    logic diag_enable;
    logic debounce_enable;
  } sample_t;

endpackage

>>> sv/dbn_if.sv
// ----------------------------------------------------------------------------
// dbn_if
// valid/ready channels of the diagnostic event debounce block
// ----------------------------------------------------------------------------
interface dbn_in_if;
  logic valid;
  logic ready;
  logic fault_active;
  logic startup_complete;
  logic diag_reset;
  logic diag_enable;
  logic debounce_enable;

  modport source (
    output valid, fault_active, startup_complete, diag_reset, diag_enable,
           debounce_enable,
    input  ready
  );
  modport sink (
    input  valid, fault_active, startup_complete, diag_reset, diag_enable,
           debounce_enable,
    output ready
  );
endinterface

interface dbn_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        event_status;
  logic signed [15:0] fault_count;

  modport source (output valid, event_status, fault_count, input ready);
  modport sink   (input valid, event_status, fault_count, output ready);
endinterface

interface dbn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/diagnostic_event_debounce.sv
// ----------------------------------------------------------------------------
// diagnostic_event_debounce
// counter based fault debounce of one diagnostic event, one sample per transaction
// ----------------------------------------------------------------------------
// an accepted input transaction passes the input register and then the result register on its way to out_ch
// throughput: one sample per cycle while out_ch is not stalled; the counter update
//   (one add/subtract, saturation and threshold compare) lies between input register
//   and result register; the debounce state is written as the result is loaded
// reset: synchronous, active low rst_n; status to init, counter and previous
//   debounce enable to zero, config registers to their defaults, pipe empty
// ----------------------------------------------------------------------------
module diagnostic_event_debounce #(
  parameter int unsigned COUNT_WIDTH = dbn_pkg::COUNT_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dbn_in_if.sink    in_ch,
  dbn_out_if.source out_ch,
  dbn_cfg_if.sink   cfg_ch
);
  import dbn_pkg::*;

  // extended width for compares: holds any counter, threshold and step sum
  localparam int unsigned EW = ((COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W) + 2;

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic signed [THR_W-1:0] fault_thr_r;
  logic signed [THR_W-1:0] pass_thr_r;
  logic [STEP_W-1:0]       up_step_r;
  logic [STEP_W-1:0]       down_step_r;
  logic                    heal_en_r;
  logic                    cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_thr_r <= FAULT_THR_RST;
      pass_thr_r  <= PASS_THR_RST;
      up_step_r   <= UP_STEP_RST;
      down_step_r <= DOWN_STEP_RST;
      heal_en_r   <= HEAL_EN_RST;
    end else if (cfg_wr) begin
      // unknown indexes are dropped
      unique case (cfg_ch.index)
        CFG_FAULT_THR: fault_thr_r <= signed'(cfg_ch.data);
        CFG_PASS_THR:  pass_thr_r  <= signed'(cfg_ch.data);
        CFG_UP_STEP:   up_step_r   <= cfg_ch.data[STEP_W-1:0];
        CFG_DOWN_STEP: down_step_r <= cfg_ch.data[STEP_W-1:0];
        CFG_HEAL_EN:   heal_en_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register stage
  // --------------------------------------------------------------------------
  logic    s1_valid_r;
  sample_t s1_r;
  logic    s1_adv;      // sample in s1 moves into the result register
  logic    in_take;
  logic    out_valid_r;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.fault_active     <= in_ch.fault_active;
      s1_r.startup_complete <= in_ch.startup_complete;
      s1_r.diag_reset       <= in_ch.diag_reset;
      s1_r.diag_enable      <= in_ch.diag_enable;
      s1_r.debounce_enable  <= in_ch.debounce_enable;
    end
  end

  // --------------------------------------------------------------------------
  // debounce state
  // --------------------------------------------------------------------------
  status_t                       status_r, status_nxt;
  logic signed [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                          prev_dbnc_r;

  // saturate an extended value to the counter range
  function automatic logic signed [COUNT_WIDTH-1:0] sat_cnt(
    input logic signed [EW-1:0] v
  );
    logic fits;
    fits = (&v[EW-1:COUNT_WIDTH-1]) || !(|v[EW-1:COUNT_WIDTH-1]);
    if (fits) begin
      return v[COUNT_WIDTH-1:0];
    end else if (v[EW-1]) begin
      return {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    end
  endfunction

  // sign extension of a counter value
  function automatic logic signed [EW-1:0] ext_cnt(
    input logic signed [COUNT_WIDTH-1:0] c
  );
    return {{(EW-COUNT_WIDTH){c[COUNT_WIDTH-1]}}, c};
  endfunction

  logic signed [EW-1:0]          cnt_ext, ft_ext, pt_ext, up_ext, dn_ext;
  logic signed [COUNT_WIDTH-1:0] up_sat, dn_sat, ft_sat, pt_sat;
  logic signed [EW-1:0]          up_sat_ext, dn_sat_ext;
  logic                          up_hit, dn_hit, up_over, dn_under;
  logic                          below_ft, above_pt;
  logic                          leave_init;  // diagnostic off or reset requested

  assign cnt_ext = ext_cnt(count_r);
  assign ft_ext  = {{(EW-THR_W){fault_thr_r[THR_W-1]}}, fault_thr_r};
  assign pt_ext  = {{(EW-THR_W){pass_thr_r[THR_W-1]}}, pass_thr_r};
  assign up_ext  = {{(EW-STEP_W){1'b0}}, up_step_r};
  assign dn_ext  = {{(EW-STEP_W){1'b0}}, down_step_r};

  // one saturating step each way, then the threshold compares
  assign up_sat     = sat_cnt(cnt_ext + up_ext);
  assign dn_sat     = sat_cnt(cnt_ext - dn_ext);
  assign ft_sat     = sat_cnt(ft_ext);
  assign pt_sat     = sat_cnt(pt_ext);
  assign up_sat_ext = ext_cnt(up_sat);
  assign dn_sat_ext = ext_cnt(dn_sat);

  assign up_hit   = up_sat_ext >= ft_ext;
  assign up_over  = up_sat_ext >  ft_ext;
  assign dn_hit   = dn_sat_ext <= pt_ext;
  assign dn_under = dn_sat_ext <  pt_ext;
  assign below_ft = cnt_ext < ft_ext;
  assign above_pt = cnt_ext > pt_ext;

  assign leave_init = s1_r.diag_reset || !s1_r.diag_enable;

  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    if (!s1_r.debounce_enable) begin
      // direct pre-status or init, counter held
      if (prev_dbnc_r || !s1_r.startup_complete || leave_init) begin
        status_nxt = ST_INIT;
      end else begin
        status_nxt = s1_r.fault_active ? ST_PREFAILED : ST_PREPASSED;
      end
    end else if (!prev_dbnc_r) begin
      // debounce just switched on
      status_nxt = ST_INIT;
      count_nxt  = '0;
    end else begin
      unique case (status_r)
        ST_INIT: begin
          if (!s1_r.startup_complete || leave_init) begin
            count_nxt = '0;
          end else if (!s1_r.fault_active) begin
            count_nxt = dn_hit ? pt_sat : dn_sat;
            if (dn_hit) status_nxt = ST_PASSED;
          end else begin
            count_nxt = up_hit ? ft_sat : up_sat;
            if (up_hit) status_nxt = ST_FAILED;
          end
        end
        ST_FAILED: begin
          if (leave_init) begin
            status_nxt = ST_INIT;
            count_nxt  = '0;
          end else if (!s1_r.fault_active) begin
            // healing only when allowed
            if (heal_en_r) begin
              count_nxt = dn_hit ? pt_sat : dn_sat;
              if (dn_hit) status_nxt = ST_PASSED;
            end
          end else if (below_ft) begin
            count_nxt = up_over ? ft_sat : up_sat;
          end
        end
        ST_PASSED: begin
          if (leave_init) begin
            status_nxt = ST_INIT;
            count_nxt  = '0;
          end else if (!s1_r.fault_active) begin
            if (above_pt) begin
              count_nxt = dn_under ? pt_sat : dn_sat;
            end
          end else begin
            count_nxt = up_hit ? ft_sat : up_sat;
            if (up_hit) status_nxt = ST_FAILED;
          end
        end
        // pre-status or bad code while debouncing falls to failed
        default: status_nxt = ST_FAILED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_INIT;
      count_r     <= '0;
      prev_dbnc_r <= 1'b0;
    end else if (s1_adv) begin
      status_r    <= status_nxt;
      count_r     <= count_nxt;
      prev_dbnc_r <= s1_r.debounce_enable;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [STATUS_W-1:0]         out_status_r;
  logic signed [OUT_CNT_W-1:0] out_count_r;
  logic signed [EW-1:0]        count_nxt_ext;

  assign count_nxt_ext = ext_cnt(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_status = out_status_r;
  assign out_ch.fault_count  = out_count_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a debounce rising edge always reports init with a cleared counter
  a_dbnc_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.debounce_enable && !prev_dbnc_r)
      |=> (out_status_r == ST_INIT && out_count_r == '0))
    else $error("debounce rising edge did not give init and zero count");

  // with debounce off the counter is never touched
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_r.debounce_enable) |=> (count_r == $past(count_r)))
    else $error("counter changed while debounce disabled");

  // a new result only appears when a sample left the input register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result raised without a sample in the input register");

  // the state only moves together with a result load
  a_state_move: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(status_r) && $stable(count_r)))
    else $error("debounce state changed without a result transaction");

endmodule
